[hw/rtl/rthsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
package rthsv_pkg;

    localparam int CH_W        = 8;
    localparam int SAT_NUM_W   = 2 * CH_W;
    localparam int HUE_Q_W     = 6;
    localparam int HUE_NUM_W   = CH_W + HUE_Q_W;
    localparam int DIV_STAGES  = CH_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [HUE_Q_W-1:0] HUE_STEP       = 6'd43;
    localparam logic [CH_W-1:0]    HUE_BASE_RED   = 8'd0;
    localparam logic [CH_W-1:0]    HUE_BASE_GREEN = 8'd85;
    localparam logic [CH_W-1:0]    HUE_BASE_BLUE  = 8'd171;

    // Classified pixel handed from the front end to the divider pipeline
    typedef struct packed {
        logic [CH_W-1:0] mx;    // largest channel
        logic [CH_W-1:0] span;  // max - min
        logic [CH_W-1:0] mag;   // |difference of the other two channels|
        logic            neg;   // difference is negative
        logic [CH_W-1:0] base;  // hue offset of the winning channel
    } cls_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic rd_valid;
    } q_stat_t;

endpackage

[hw/rtl/rthsv_front.sv]
// Front end: accepts a pixel word and classifies it by its largest channel.
module rthsv_front (
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic            in_valid,
    output logic            in_ready,
    input  rthsv_pkg::q_stat_t q_stat,
    output logic            push,
    output rthsv_pkg::cls_t cls
);
    import rthsv_pkg::*;

    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] pos_ch;
    logic [CH_W-1:0] neg_ch;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // Max and min of the three channels
    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    // Winning channel picks the offset; red beats green beats blue on ties
    always_comb
    begin
        if (red == mx)
        begin
            cls.base = HUE_BASE_RED;
            pos_ch   = green;
            neg_ch   = blue;
        end
        else if (green == mx)
        begin
            cls.base = HUE_BASE_GREEN;
            pos_ch   = blue;
            neg_ch   = red;
        end
        else
        begin
            cls.base = HUE_BASE_BLUE;
            pos_ch   = red;
            neg_ch   = green;
        end
        cls.mx   = mx;
        cls.span = mx - mn;
        cls.neg  = neg_ch > pos_ch;
        cls.mag  = cls.neg ? (neg_ch - pos_ch) : (pos_ch - neg_ch);
    end

endmodule

[hw/rtl/rthsv_queue.sv]
// Short queue between the front end and the divider pipeline.
module rthsv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rthsv_pkg::cls_t    wr_data,
    input  logic               pop,
    output rthsv_pkg::cls_t    rd_data,
    output rthsv_pkg::q_stat_t q_stat
);
    import rthsv_pkg::*;

    cls_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_pop;

    assign q_stat.full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_stat.rd_valid = (count_reg != '0);
    assign rd_data         = mem_reg[rd_ptr_reg];
    assign do_pop          = pop && q_stat.rd_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/rthsv_back.sv]
// Back end: two restoring dividers, at most one quotient bit per stage each, and the hue sum.
module rthsv_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cls_valid,
    input  rthsv_pkg::cls_t cls,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      hue,
    output logic [7:0]      saturation,
    output logic [7:0]      value
);
    import rthsv_pkg::*;

    typedef struct packed {
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [CH_W-1:0]      sat_q;
        logic [CH_W-1:0]      sat_div;
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_Q_W-1:0]   hue_q;
        logic [CH_W-1:0]      hue_div;
        logic                 neg;
        logic [CH_W-1:0]      base;
        logic [CH_W-1:0]      mx;
        logic                 grey;
    } stg_t;

    // One quotient bit of each divider; the hue quotient has only six bits
    function automatic stg_t div_step(input stg_t s, input logic [2:0] j);
        stg_t                 r;
        logic [2:0]           sh;
        logic [SAT_NUM_W-1:0] sat_d;
        logic [HUE_NUM_W-1:0] hue_d;
        r     = s;
        sh    = 3'd7 - j;
        sat_d = SAT_NUM_W'(s.sat_div) << sh;
        hue_d = HUE_NUM_W'(s.hue_div) << sh;
        if (s.sat_rem >= sat_d)
        begin
            r.sat_rem = s.sat_rem - sat_d;
            r.sat_q   = {s.sat_q[CH_W-2:0], 1'b1};
        end
        else
        begin
            r.sat_q = {s.sat_q[CH_W-2:0], 1'b0};
        end
        if (j >= 3'(CH_W - HUE_Q_W))
        begin
            if (s.hue_rem >= hue_d)
            begin
                r.hue_rem = s.hue_rem - hue_d;
                r.hue_q   = {s.hue_q[HUE_Q_W-2:0], 1'b1};
            end
            else
            begin
                r.hue_q = {s.hue_q[HUE_Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic                 adv;
    logic                 vld_reg [DIV_STAGES+1];
    stg_t                 stg_reg [DIV_STAGES+1];
    stg_t                 stg_next [DIV_STAGES+1];
    logic [CH_W-1:0]      hue_next;
    logic [CH_W-1:0]      hue_reg;
    logic [CH_W-1:0]      sat_reg;
    logic [CH_W-1:0]      value_reg;
    logic                 out_valid_reg;

    // Whole pipeline moves when the output word is free or being taken
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv;

    // Stage 0: numerators and guarded divisors; each later stage takes one divider step
    always_comb
    begin
        stg_next[0].sat_rem = {cls.span, 8'd0} - SAT_NUM_W'(cls.span);
        stg_next[0].sat_q   = '0;
        stg_next[0].sat_div = (cls.mx == '0) ? 8'd1 : cls.mx;
        stg_next[0].hue_rem = HUE_NUM_W'(cls.mag) * HUE_NUM_W'(HUE_STEP);
        stg_next[0].hue_q   = '0;
        stg_next[0].hue_div = (cls.span == '0) ? 8'd1 : cls.span;
        stg_next[0].neg     = cls.neg;
        stg_next[0].base    = cls.base;
        stg_next[0].mx      = cls.mx;
        stg_next[0].grey    = (cls.span == '0);
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            stg_next[j+1] = div_step(stg_reg[j], 3'(j));
        end
    end

    // Hue offset plus or minus the quotient, wrapped to eight bits; zero for a grey pixel
    always_comb
    begin
        if (stg_reg[DIV_STAGES].grey)
        begin
            hue_next = '0;
        end
        else if (stg_reg[DIV_STAGES].neg)
        begin
            hue_next = stg_reg[DIV_STAGES].base - CH_W'(stg_reg[DIV_STAGES].hue_q);
        end
        else
        begin
            hue_next = stg_reg[DIV_STAGES].base + CH_W'(stg_reg[DIV_STAGES].hue_q);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= cls_valid;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[DIV_STAGES];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
            hue_reg   <= hue_next;
            sat_reg   <= stg_reg[DIV_STAGES].sat_q;
            value_reg <= stg_reg[DIV_STAGES].mx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

endmodule

[hw/rtl/rgb_to_hsv_8bit_integer_unit.sv]
// Top level of the 8-bit RGB to HSV converter.
//
// Input channel: red, green, blue with in_valid / in_ready. A word is taken
// at a rising edge where both are high. Output channel: hue, saturation,
// value with out_valid / out_ready, same rule.
// Throughput: one pixel per clock while the receiver keeps out_ready high.
// Path: with no stall, an input word passes through the 4-entry queue, the
// numerator register, eight restoring-divider stages (one quotient bit each
// for saturation, and for hue in the last six), and the output register with
// the hue sum. While out_valid is high and out_ready is low the divider
// pipeline holds; the queue keeps taking words until its four entries are
// full, then in_ready drops.
// Reset clears the queue and all valid bits; no word is in flight after it.
module rgb_to_hsv_8bit_integer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready
);
    import rthsv_pkg::*;

    q_stat_t q_stat;
    cls_t    front_cls;
    cls_t    queue_cls;
    logic    push;
    logic    pop;

    rthsv_front u_front (
        .red      (red),
        .green    (green),
        .blue     (blue),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_stat   (q_stat),
        .push     (push),
        .cls      (front_cls)
    );

    rthsv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cls),
        .pop     (pop),
        .rd_data (queue_cls),
        .q_stat  (q_stat)
    );

    rthsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls_valid  (q_stat.rd_valid),
        .cls        (queue_cls),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .value      (value)
    );

endmodule

[hw/rtl/rthsv_checker.sv]
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rthsv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] value,
    input logic       out_valid,
    input logic       out_ready
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
            && $stable(value))
        else $error("output word changed while stalled");

    // Black pixel has no hue and no saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value == 8'd0 |-> saturation == 8'd0 && hue == 8'd0)
        else $error("black pixel with nonzero hue or saturation");

    // Grey pixel has no hue
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == 8'd0 |-> hue == 8'd0)
        else $error("zero saturation with nonzero hue");

    // Queue can only fill by taking a word
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready dropped without an input word");

endmodule

bind rgb_to_hsv_8bit_integer_unit rthsv_checker u_chk (.*);
